@@ rtl/dsjm_pkg.sv @@
package dsjm_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned HIT_POS_W  = 16;
  localparam int unsigned OFFSET_W   = 7;

  typedef enum logic [2:0] {
    REG_MASK_A       = 3'd0,
    REG_MASK_C       = 3'd1,
    REG_MASK_G       = 3'd2,
    REG_MASK_T       = 3'd3,
    REG_LENGTH_MASK  = 3'd4,
    REG_SPLIT_OFFSET = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    BASE_A = 3'd0,
    BASE_C = 3'd1,
    BASE_G = 3'd2,
    BASE_T = 3'd3
  } base_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] mask_a;
    logic [CFG_DATA_W-1:0] mask_c;
    logic [CFG_DATA_W-1:0] mask_g;
    logic [CFG_DATA_W-1:0] mask_t;
    logic [CFG_DATA_W-1:0] length_mask;
    logic [OFFSET_W-1:0]   split_offset;
  } cfg_t;

endpackage

@@ rtl/dsjm_base_if.sv @@
interface dsjm_base_if;
  logic       valid;
  logic       ready;
  logic [2:0] base_code;
  logic       read_start;

  modport source (output valid, output base_code, output read_start, input ready);
  modport sink   (input valid, input base_code, input read_start, output ready);
endinterface

@@ rtl/dsjm_hit_if.sv @@
interface dsjm_hit_if;
  logic        valid;
  logic        ready;
  logic [15:0] hit_position;

  modport source (output valid, output hit_position, input ready);
  modport sink   (input valid, input hit_position, output ready);
endinterface

@@ rtl/dna_shift_or_junction_matcher_top.sv @@
// Shift-or exact matcher for a stream of encoded DNA bases.
// base_in carries one base per request (base_code, read_start); hit_out
// carries one hit_position per match that ends at a base. Bases that end
// no match give nothing on hit_out.
// The APB port loads the four base masks, the length mask and the split
// offset, 8 bytes per register; load them only while the stream is idle.
// Throughput: one base per cycle while base_in.ready is high. Each base
// updates the match vector, base index and saturation flag in the cycle
// it is accepted; a hit lands in a two-entry output queue for hit_out.
// A stalled hit_out holds its request; the queue keeps taking bases until
// both entries are full, then base_in.ready drops until a hit is taken.
// Reset: masks go to all ones, split offset to zero, match vector to all
// ones, index and saturation flag to zero, output queue empty.
module dna_shift_or_junction_matcher_top #(
  parameter int unsigned PATTERN_BITS  = 64,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dsjm_base_if.sink                       base_in,
  dsjm_hit_if.source                      hit_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsjm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dsjm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dsjm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dsjm_pkg::*;

  cfg_t                 cfg;
  logic                 accept, hit, space;
  logic [HIT_POS_W-1:0] hit_pos;

  assign base_in.ready = space;
  assign accept        = base_in.valid && space;

  dsjm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsjm_core #(
    .PATTERN_BITS  (PATTERN_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .accept_i       (accept),
    .base_code_i    (base_in.base_code),
    .read_start_i   (base_in.read_start),
    .hit_o          (hit),
    .hit_position_o (hit_pos)
  );

  dsjm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && hit),
    .push_data_i (hit_pos),
    .space_o     (space),
    .valid_o     (hit_out.valid),
    .ready_i     (hit_out.ready),
    .data_o      (hit_out.hit_position)
  );
endmodule

@@ rtl/dsjm_cfg_regs.sv @@
module dsjm_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsjm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dsjm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dsjm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output dsjm_pkg::cfg_t                  cfg_o
);
  import dsjm_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // registers sit on 8-byte boundaries
  assign reg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_a       <= '1;
      cfg_q.mask_c       <= '1;
      cfg_q.mask_g       <= '1;
      cfg_q.mask_t       <= '1;
      cfg_q.length_mask  <= '1;
      cfg_q.split_offset <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MASK_A:       cfg_q.mask_a       <= pwdata;
        REG_MASK_C:       cfg_q.mask_c       <= pwdata;
        REG_MASK_G:       cfg_q.mask_g       <= pwdata;
        REG_MASK_T:       cfg_q.mask_t       <= pwdata;
        REG_LENGTH_MASK:  cfg_q.length_mask  <= pwdata;
        REG_SPLIT_OFFSET: cfg_q.split_offset <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MASK_A:       prdata = cfg_q.mask_a;
      REG_MASK_C:       prdata = cfg_q.mask_c;
      REG_MASK_G:       prdata = cfg_q.mask_g;
      REG_MASK_T:       prdata = cfg_q.mask_t;
      REG_LENGTH_MASK:  prdata = cfg_q.length_mask;
      REG_SPLIT_OFFSET: prdata = CFG_DATA_W'(cfg_q.split_offset);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

@@ rtl/dsjm_core.sv @@
module dsjm_core #(
  parameter int unsigned PATTERN_BITS  = 64,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dsjm_pkg::cfg_t                 cfg_i,
  input  logic                           accept_i,
  input  logic [2:0]                     base_code_i,
  input  logic                           read_start_i,
  output logic                           hit_o,
  output logic [dsjm_pkg::HIT_POS_W-1:0] hit_position_o
);
  import dsjm_pkg::*;

  logic [PATTERN_BITS-1:0]  vec_q, vec_d, vec_base, base_mask;
  logic [POSITION_BITS-1:0] idx_q, idx_d, pos;
  logic                     sat_q, sat_d;
  logic [31:0]              pos_ext;

  always_comb begin
    case (base_e'(base_code_i))
      BASE_A:  base_mask = cfg_i.mask_a[PATTERN_BITS-1:0];
      BASE_C:  base_mask = cfg_i.mask_c[PATTERN_BITS-1:0];
      BASE_G:  base_mask = cfg_i.mask_g[PATTERN_BITS-1:0];
      BASE_T:  base_mask = cfg_i.mask_t[PATTERN_BITS-1:0];
      default: base_mask = cfg_i.length_mask[PATTERN_BITS-1:0];
    endcase
  end

  always_comb begin
    vec_base = vec_q;
    idx_d    = idx_q;
    sat_d    = sat_q;
    if (read_start_i) begin
      vec_base = cfg_i.length_mask[PATTERN_BITS-1:0];
      idx_d    = '0;
      sat_d    = 1'b0;
    end else if (&idx_q) begin
      // index pinned at max; results muted until the next read start
      sat_d = 1'b1;
    end else begin
      idx_d = idx_q + POSITION_BITS'(1);
    end
    vec_d   = (vec_base >> 1) | base_mask;
    pos     = idx_d - POSITION_BITS'(cfg_i.split_offset);
    pos_ext = 32'(pos);
  end

  assign hit_o          = !vec_d[0] && !sat_d;
  assign hit_position_o = pos_ext[HIT_POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '1;
      idx_q <= '0;
      sat_q <= 1'b0;
    end else if (accept_i) begin
      vec_q <= vec_d;
      idx_q <= idx_d;
      sat_q <= sat_d;
    end
  end
endmodule

@@ rtl/dsjm_out_buf.sv @@
module dsjm_out_buf (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [dsjm_pkg::HIT_POS_W-1:0] push_data_i,
  output logic                           space_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [dsjm_pkg::HIT_POS_W-1:0] data_o
);
  import dsjm_pkg::*;

  // two slots: one result on show plus one caught while the sink stalls
  logic [HIT_POS_W-1:0] data_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 pop;

  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign data_o  = data_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop)    rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

@@ rtl/dsjm_checker.sv @@
module dsjm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pos
);

  // a pending hit is never dropped or changed while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pos))
    else $error("hit request changed while stalled");

  // base_in only backs up when the output queue is holding hits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with no hit pending");

  // a hit can only appear after a base was taken
  a_hit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("hit without an accepted base");

endmodule

bind dna_shift_or_junction_matcher_top dsjm_checker u_dsjm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (base_in.valid),
  .in_ready  (base_in.ready),
  .out_valid (hit_out.valid),
  .out_ready (hit_out.ready),
  .out_pos   (hit_out.hit_position)
);

@@ sim/dna_shift_or_junction_matcher_top_tb.sv @@
`timescale 1ns / 1ps

module dna_shift_or_junction_matcher_top_tb;
  import dsjm_pkg::*;

  localparam int unsigned PATTERN_BITS  = 64;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned PAUSE_PHASE   = 5;
  localparam int unsigned MAX_PRINTS    = 50;

  // codes 4..7 are N or extended bases, never in the masks
  localparam logic [2:0] BASE_N    = 3'd4;
  localparam logic [2:0] BASE_EXT5 = 3'd5;
  localparam logic [2:0] BASE_EXT6 = 3'd6;
  localparam logic [2:0] BASE_EXT7 = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_6 = 6'd48;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_7 = 6'd56;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NO_HIT,
    CHK_HIT
  } chk_e;

  typedef enum logic [1:0] {
    MODE_RX_BUSY,
    MODE_TX_BUSY,
    MODE_FREE
  } pace_e;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  code;
    logic        start;
    chk_e        chk;
    logic [15:0] pos;
  } dir_row_t;

  localparam int N_DIRECTED = 22;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // reset state, with and without a read start: all-ones masks never match
    '{3'd0, BASE_A,    1'b0, CHK_NO_HIT,  16'd0},
    '{3'd0, BASE_EXT7, 1'b1, CHK_NO_HIT,  16'd0},
    '{3'd0, BASE_T,    1'b0, CHK_NO_HIT,  16'd0},
    // pattern ACG, offset 0
    '{3'd1, BASE_A,    1'b1, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_C,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_G,    1'b0, CHK_HIT,     16'd2},
    '{3'd1, BASE_T,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_EXT5, 1'b0, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_A,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_C,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd1, BASE_G,    1'b0, CHK_HIT,     16'd7},
    // pattern T, offset 64: position wraps
    '{3'd2, BASE_T,    1'b1, CHK_HIT,     16'd65472},
    '{3'd2, BASE_A,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd2, BASE_T,    1'b0, CHK_HIT,     16'd65474},
    '{3'd2, BASE_N,    1'b0, CHK_NO_HIT,  16'd0},
    '{3'd2, BASE_EXT6, 1'b0, CHK_PREDICT, 16'd0},
    // all masks zero: every base hits, N too
    '{3'd3, BASE_N,    1'b1, CHK_HIT,     16'd0},
    '{3'd3, BASE_EXT7, 1'b0, CHK_HIT,     16'd1},
    '{3'd3, BASE_A,    1'b0, CHK_PREDICT, 16'd0},
    '{3'd3, BASE_C,    1'b1, CHK_HIT,     16'd0},
    // all masks ones: nothing matches
    '{3'd4, BASE_G,    1'b1, CHK_NO_HIT,  16'd0},
    '{3'd4, BASE_T,    1'b0, CHK_NO_HIT,  16'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  dsjm_base_if base_if ();
  dsjm_hit_if  hit_if ();

  dna_shift_or_junction_matcher_top #(
    .PATTERN_BITS (PATTERN_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .base_in(base_if),
    .hit_out(hit_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the block
  cfg_t                     shadow_cfg;
  logic [PATTERN_BITS-1:0]  match_vec;
  logic [POSITION_BITS-1:0] match_idx;
  bit                       idx_sat;

  logic [15:0] hits_pending [$];
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  pace_e       pace_mode;
  int unsigned hold_asked;
  int unsigned hold_taken;
  int unsigned hold_left;

  logic [2:0] motif [PATTERN_BITS];
  int         motif_len;

  always #(CLK_HALF) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_e r);
    return {r, 3'b000};
  endfunction

  function automatic logic [2:0] random_base();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(4, 7));
    return 3'($urandom_range(0, 3));
  endfunction

  function automatic logic [63:0] cfg_value(input reg_idx_e r);
    case (r)
      REG_MASK_A:      return shadow_cfg.mask_a;
      REG_MASK_C:      return shadow_cfg.mask_c;
      REG_MASK_G:      return shadow_cfg.mask_g;
      REG_MASK_T:      return shadow_cfg.mask_t;
      REG_LENGTH_MASK: return shadow_cfg.length_mask;
      default:         return {57'd0, shadow_cfg.split_offset};
    endcase
  endfunction

  // one base through the shift-or update; hit_pos valid when hit is set
  function automatic void advance_matcher(input logic [2:0] code, input logic start,
                                          output bit hit, output logic [15:0] hit_pos);
    logic [PATTERN_BITS-1:0] m;
    if (start) begin
      match_vec = shadow_cfg.length_mask[PATTERN_BITS-1:0];
      match_idx = '0;
      idx_sat   = 1'b0;
    end else if (&match_idx) begin
      idx_sat = 1'b1;
    end else begin
      match_idx = match_idx + POSITION_BITS'(1);
    end
    case (code)
      BASE_A:  m = shadow_cfg.mask_a[PATTERN_BITS-1:0];
      BASE_C:  m = shadow_cfg.mask_c[PATTERN_BITS-1:0];
      BASE_G:  m = shadow_cfg.mask_g[PATTERN_BITS-1:0];
      BASE_T:  m = shadow_cfg.mask_t[PATTERN_BITS-1:0];
      default: m = shadow_cfg.length_mask[PATTERN_BITS-1:0];
    endcase
    match_vec = (match_vec >> 1) | m;
    hit       = !match_vec[0] && !idx_sat;
    hit_pos   = 16'(match_idx - POSITION_BITS'(shadow_cfg.split_offset));
  endfunction

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] a, input logic [63:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e r, input logic [63:0] v);
    apb_write(reg_addr(r), v);
    case (r)
      REG_MASK_A:      shadow_cfg.mask_a = v;
      REG_MASK_C:      shadow_cfg.mask_c = v;
      REG_MASK_G:      shadow_cfg.mask_g = v;
      REG_MASK_T:      shadow_cfg.mask_t = v;
      REG_LENGTH_MASK: shadow_cfg.length_mask = v;
      default:         shadow_cfg.split_offset = v[OFFSET_W-1:0];
    endcase
  endtask

  task automatic verify_cfg();
    logic [63:0] got;
    reg_idx_e    ri;
    for (int r = 0; r <= REG_SPLIT_OFFSET; r++) begin
      ri      = reg_idx_e'(r);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= reg_addr(ri);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== cfg_value(ri))
        report_mismatch($sformatf("register %s readback", ri.name()), got,
                        cfg_value(ri));
      @(posedge clk_i);
    end
  endtask

  // stop offering, let every hit come back, then cover the pipe latency
  task automatic settle_stream();
    base_if.valid <= 1'b0;
    @(posedge clk_i);
    while (hits_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic offer_base(input logic [2:0] code, input logic start);
    int unsigned gap_pct;
    gap_pct = (pace_mode == MODE_RX_BUSY) ? 11 : (pace_mode == MODE_TX_BUSY) ? 80 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      base_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    base_if.valid      <= 1'b1;
    base_if.base_code  <= code;
    base_if.read_start <= start;
    do @(posedge clk_i); while (!base_if.ready);
  endtask

  task automatic stream_base(input logic [2:0] code, input logic start);
    bit          hit;
    logic [15:0] hit_pos;
    offer_base(code, start);
    advance_matcher(code, start, hit, hit_pos);
    if (hit) hits_pending.push_back(hit_pos);
  endtask

  task automatic load_directed_cfg(input int phase);
    case (phase)
      1: begin
        cfg_write(REG_MASK_A, 64'h3);
        cfg_write(REG_MASK_C, 64'h5);
        cfg_write(REG_MASK_G, 64'h6);
        cfg_write(REG_MASK_T, 64'h7);
        cfg_write(REG_LENGTH_MASK, 64'h7);
        cfg_write(REG_SPLIT_OFFSET, 64'd0);
        apb_write(UNMAPPED_ADDR_6, 64'd0);
      end
      2: begin
        cfg_write(REG_MASK_A, 64'h1);
        cfg_write(REG_MASK_C, 64'h1);
        cfg_write(REG_MASK_G, 64'h1);
        cfg_write(REG_MASK_T, 64'h0);
        cfg_write(REG_LENGTH_MASK, 64'h1);
        cfg_write(REG_SPLIT_OFFSET, 64'd64);
      end
      3: begin
        cfg_write(REG_MASK_A, '0);
        cfg_write(REG_MASK_C, '0);
        cfg_write(REG_MASK_G, '0);
        cfg_write(REG_MASK_T, '0);
        cfg_write(REG_LENGTH_MASK, '0);
        cfg_write(REG_SPLIT_OFFSET, 64'd0);
      end
      default: begin
        cfg_write(REG_MASK_A, '1);
        cfg_write(REG_MASK_C, '1);
        cfg_write(REG_MASK_G, '1);
        cfg_write(REG_MASK_T, '1);
        cfg_write(REG_LENGTH_MASK, '1);
        cfg_write(REG_SPLIT_OFFSET, 64'd0);
      end
    endcase
    verify_cfg();
  endtask

  // new motif, masks folded from it with some degenerate positions (random in phases 4, 10; zero in 7)
  task automatic load_random_cfg(input int phase);
    logic [63:0] vals [6];
    logic [63:0] len_mask;
    int          ch;
    case (phase)
      0:       motif_len = PATTERN_BITS;
      1:       motif_len = 1;
      default: motif_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, PATTERN_BITS)
                                                       : $urandom_range(1, 8);
    endcase
    for (int i = 0; i < motif_len; i++) motif[i] = 3'($urandom_range(0, 3));
    len_mask = (motif_len == 64) ? '1 : (64'd1 << motif_len) - 64'd1;
    // bits above the motif stay clear so a match can begin at any base
    for (int b = 0; b < 4; b++) vals[b] = len_mask;
    for (int b = 0; b < motif_len; b++) begin
      ch = motif[motif_len-1-b];
      vals[ch][b] = 1'b0;
      if ($urandom_range(0, 5) == 0) vals[$urandom_range(0, 3)][b] = 1'b0;
    end
    vals[REG_LENGTH_MASK]  = len_mask;
    vals[REG_SPLIT_OFFSET] = (phase == 0) ? 64'd64 : (phase == 1) ? 64'd0
                                                   : 64'($urandom_range(0, 64));
    if (phase == 4 || phase == 10) begin
      for (int b = 0; b <= REG_LENGTH_MASK; b++) vals[b] = {$urandom, $urandom};
    end else if (phase == 7) begin
      for (int b = 0; b <= REG_LENGTH_MASK; b++) vals[b] = '0;
    end
    for (int r = 0; r <= REG_SPLIT_OFFSET; r++) cfg_write(reg_idx_e'(r), vals[r]);
    apb_write(($urandom_range(0, 1) != 0) ? UNMAPPED_ADDR_6 : UNMAPPED_ADDR_7,
              {$urandom, $urandom});
    verify_cfg();
  endtask

  task automatic run_random_phase(input int phase);
    int         left;
    int         read_len;
    int         plant_left;
    int         flip_at;
    bit         noisy;
    bit         paused;
    logic [2:0] code;
    logic       start;
    left   = PHASE_ITEMS;
    paused = 1'b0;
    while (left > 0) begin
      noisy      = ($urandom_range(0, 9) == 0);
      read_len   = $urandom_range(1, 2 * motif_len + 12);
      plant_left = 0;
      flip_at    = -1;
      for (int i = 0; i < read_len && left > 0; i++) begin
        if (noisy) begin
          // broken reads: starts anywhere, any code
          code  = 3'($urandom_range(0, 7));
          start = ($urandom_range(0, 5) == 0);
        end else begin
          start = (i == 0);
          if (plant_left == 0 && $urandom_range(0, 99) < 35) begin
            plant_left = motif_len;
            flip_at    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, motif_len) : -1;
          end
          if (plant_left != 0) begin
            code = (plant_left == flip_at) ? random_base() : motif[motif_len-plant_left];
            plant_left--;
          end else begin
            code = random_base();
          end
        end
        stream_base(code, start);
        left--;
      end
      if (phase == PAUSE_PHASE && !paused && left < PHASE_ITEMS / 2) begin
        paused = 1'b1;
        base_if.valid <= 1'b0;
        do @(posedge clk_i); while (hits_pending.size() != 0);
      end
    end
  endtask

  // receiver: random ready, with an occasional long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hit_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
      hit_if.ready <= 1'b0;
    end else begin
      case (pace_mode)
        MODE_RX_BUSY: hit_if.ready <= ($urandom_range(0, 99) >= 80);
        MODE_TX_BUSY: hit_if.ready <= ($urandom_range(0, 99) >= 11);
        default:      hit_if.ready <= 1'b1;
      endcase
    end
  end

  // hit checker and watchdog
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni) begin
      if (hit_if.valid && hit_if.ready) begin
        if (hits_pending.size() == 0) begin
          report_mismatch("hit with none expected", hit_if.hit_position, 0);
        end else begin
          want = hits_pending.pop_front();
          if (hit_if.hit_position !== want)
            report_mismatch("hit_position", hit_if.hit_position, want);
        end
      end
      if ((hit_if.valid && hit_if.ready) || (base_if.valid && base_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("dna_shift_or_junction_matcher_top_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    row;
    int          cur_phase;
    bit          hit;
    logic [15:0] hit_pos;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    base_if.valid      = 1'b0;
    base_if.base_code  = BASE_A;
    base_if.read_start = 1'b0;
    hit_if.ready       = 1'b0;
    mismatch_count     = 0;
    stall_cycles       = 0;
    hold_asked         = 0;
    hold_taken         = 0;
    hold_left          = 0;
    pace_mode          = MODE_RX_BUSY;
    shadow_cfg         = '{mask_a: '1, mask_c: '1, mask_g: '1, mask_t: '1,
                           length_mask: '1, split_offset: '0};
    match_vec          = '1;
    match_idx          = '0;
    idx_sat            = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    cur_phase = 0;
    verify_cfg();
    for (int n = 0; n < N_DIRECTED; n++) begin
      row = DIRECTED[n];
      if (row.phase != cur_phase) begin
        settle_stream();
        cur_phase = row.phase;
        load_directed_cfg(cur_phase);
      end
      offer_base(row.code, row.start);
      advance_matcher(row.code, row.start, hit, hit_pos);
      case (row.chk)
        CHK_PREDICT: if (hit) hits_pending.push_back(hit_pos);
        CHK_HIT:     hits_pending.push_back(row.pos);
        default:     ;
      endcase
    end

    // random reads over a range of settings and pacing
    for (int p = 0; p < PHASES; p++) begin
      settle_stream();
      pace_mode = (p < 4) ? MODE_RX_BUSY : (p < 8) ? MODE_TX_BUSY : MODE_FREE;
      load_random_cfg(p);
      run_random_phase(p);
    end

    // a run of A's: every A hits, so the held-off receiver fills the queue
    // and stalls input.
    settle_stream();
    pace_mode = MODE_FREE;
    cfg_write(REG_MASK_A, 64'h0);
    cfg_write(REG_MASK_C, 64'h1);
    cfg_write(REG_MASK_G, 64'h1);
    cfg_write(REG_MASK_T, 64'h1);
    cfg_write(REG_LENGTH_MASK, 64'h1);
    cfg_write(REG_SPLIT_OFFSET, 64'd5);
    hold_asked++;
    stream_base(BASE_A, 1'b1);
    repeat (20) stream_base(BASE_A, 1'b0);
    stream_base(BASE_A, 1'b0);
    stream_base(BASE_C, 1'b0);
    stream_base(BASE_EXT6, 1'b0);
    stream_base(BASE_A, 1'b0);
    stream_base(BASE_A, 1'b1);
    stream_base(BASE_A, 1'b0);

    settle_stream();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && hits_pending.size() == 0) begin
      $display("dna_shift_or_junction_matcher_top_tb: done, clean");
    end else begin
      $display("dna_shift_or_junction_matcher_top_tb: done, errors");
    end
    $finish;
  end

endmodule
